>>> hw/rtl/etf_pkg.sv
// etf_pkg: shared types, codes and defaults of the euler trail unit
// used by etf_ctrl, etf_datapath and euler_trail_fleury_unit; no dependencies
package etf_pkg;

  localparam int NUM_VERTICES_DEF = 8;
  localparam int MAX_EDGES_DEF    = 64;
  localparam int VTX_W            = 3;
  localparam int CNT_W            = 4;
  localparam logic [CNT_W-1:0] PAIR_MAX = 4'd15;

  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_RUN = 1'b1;

  typedef enum logic [1:0] {
    ST_EDGE      = 2'd0,
    ST_NOT_EULER = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic latch_add;
    logic add_commit;
    logic check;
    logic pick;
    logic test_cnt;
    logic reach_step;
    logic take;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic add_ok;
    logic check_err;
    logic pick_none;
    logic cnt_take;
    logic reach_hit;
    logic reach_stable;
  } sts_t;

endpackage

>>> hw/rtl/etf_ram.sv
// etf_ram: generic single-port ram with registered read
// no dependencies
module etf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> hw/rtl/etf_datapath.sv
// etf_datapath: pair count ram, adjacency bits, parity, reach closure, result register
// depends on etf_pkg and etf_ram
module etf_datapath #(
  parameter int NUM_VERTICES = 8,
  parameter int MAX_EDGES    = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  etf_pkg::cmd_t              cmd_i,
  output etf_pkg::sts_t              sts_o,
  input  logic [etf_pkg::VTX_W-1:0]  vertex_a_i,
  input  logic [etf_pkg::VTX_W-1:0]  vertex_b_i,
  output logic                       result_valid_o,
  output logic [1:0]                 status_o,
  output logic [etf_pkg::VTX_W-1:0]  from_vertex_o,
  output logic [etf_pkg::VTX_W-1:0]  to_vertex_o,
  output logic                       last_o
);
  import etf_pkg::*;

  localparam int NV = NUM_VERTICES;
  localparam int VW = $clog2(NUM_VERTICES);
  localparam int AW = 2 * VW;
  localparam int TW = $clog2(MAX_EDGES + 1);

  function automatic logic [AW-1:0] pair_addr(logic [VW-1:0] x, logic [VW-1:0] y);
    if (x < y) return {x, y};
    return {y, x};
  endfunction

  function automatic logic [VW-1:0] lowest(logic [NV-1:0] m);
    logic [VW-1:0] r;
    r = '0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (m[i]) r = VW'(i);
    end
    return r;
  endfunction

  function automatic logic [VW-1:0] highest(logic [NV-1:0] m);
    logic [VW-1:0] r;
    r = '0;
    for (int i = 0; i < NV; i++) begin
      if (m[i]) r = VW'(i);
    end
    return r;
  endfunction

  function automatic logic [VW:0] ones(logic [NV-1:0] m);
    logic [VW:0] r;
    r = '0;
    for (int i = 0; i < NV; i++) begin
      r = r + (VW+1)'(m[i]);
    end
    return r;
  endfunction

  function automatic logic [VTX_W-1:0] to_port(logic [VW-1:0] x);
    return VTX_W'(5'(x));
  endfunction

  logic [NV-1:0]    nz_q [NV];
  logic [NV-1:0]    par_q;
  logic [TW-1:0]    total_q;
  logic             ovf_q;
  logic [VW-1:0]    a_q, b_q, cur_q, v_q;
  logic [AW-1:0]    addr_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NV-1:0]    rem_q, vis_q;
  logic [VW-1:0]    pend_from_q, pend_to_q;
  logic             pend_v_q;
  logic             res_valid_q, res_last_q;
  logic [1:0]       res_status_q;
  logic [VW-1:0]    res_from_q, res_to_q;

  // input endpoints
  logic [4:0]    a_wide, b_wide;
  logic [VW-1:0] a_idx, b_idx;
  assign a_wide = {2'b00, vertex_a_i};
  assign b_wide = {2'b00, vertex_b_i};
  assign a_idx  = VW'(a_wide);
  assign b_idx  = VW'(b_wide);

  // ram
  logic [AW-1:0]    ram_addr;
  logic             ram_we;
  logic [CNT_W-1:0] ram_wdata, ram_rdata;
  logic [VW-1:0]    pick_v;
  logic [CNT_W-1:0] eff_cnt;
  logic             add_full;

  assign pick_v   = lowest(rem_q);
  assign eff_cnt  = nz_q[a_q][b_q] ? ram_rdata : '0;
  assign add_full = (total_q >= TW'(MAX_EDGES)) || (eff_cnt >= PAIR_MAX);

  always_comb begin
    ram_addr  = addr_q;
    ram_we    = 1'b0;
    ram_wdata = cnt_q - CNT_W'(1);
    if (cmd_i.latch_add) begin
      ram_addr = pair_addr(a_idx, b_idx);
    end else if (cmd_i.pick) begin
      ram_addr = pair_addr(cur_q, pick_v);
    end
    if (cmd_i.add_commit && !add_full) begin
      ram_we    = 1'b1;
      ram_wdata = eff_cnt + CNT_W'(1);
    end else if (cmd_i.take) begin
      ram_we = 1'b1;
    end
  end

  etf_ram #(.WIDTH(CNT_W), .DEPTH(2 ** AW)) u_ram (
    .clk_i  (clk_i),
    .addr_i (ram_addr),
    .we_i   (ram_we),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // run checks
  logic [VW:0]   odd_cnt;
  logic [1:0]    err_code;
  logic          err;
  assign odd_cnt = ones(par_q);
  always_comb begin
    err      = 1'b1;
    err_code = ST_OVERFLOW;
    if (ovf_q) begin
      err_code = ST_OVERFLOW;
    end else if (total_q == '0) begin
      err_code = ST_EMPTY;
    end else if (odd_cnt != '0 && odd_cnt != (VW+1)'(2)) begin
      err_code = ST_NOT_EULER;
    end else begin
      err = 1'b0;
    end
  end

  // reach closure over adjacency with the tested edge removed
  logic [NV-1:0] vis_d;
  always_comb begin
    logic [NV-1:0] row;
    vis_d = vis_q;
    for (int w = 0; w < NV; w++) begin
      row = nz_q[w];
      if (VW'(w) == cur_q) row[v_q] = 1'b0;
      if (VW'(w) == v_q) row[cur_q] = 1'b0;
      if (vis_q[w]) vis_d = vis_d | row;
    end
  end

  assign sts_o.add_ok       = (a_wide < 5'(NV)) && (b_wide < 5'(NV)) && (a_wide != b_wide);
  assign sts_o.check_err    = err;
  assign sts_o.pick_none    = (rem_q == '0);
  assign sts_o.cnt_take     = (ram_rdata >= CNT_W'(2)) ||
                              (ones(nz_q[cur_q]) == (VW+1)'(1));
  assign sts_o.reach_hit    = vis_d[v_q];
  assign sts_o.reach_stable = (vis_d == vis_q);

  logic [NV-1:0] next_row;
  always_comb begin
    next_row = nz_q[v_q];
    if (cnt_q == CNT_W'(1)) next_row[cur_q] = 1'b0;
  end

  // store state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NV; i++) nz_q[i] <= '0;
      par_q    <= '0;
      total_q  <= '0;
      ovf_q    <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      if (cmd_i.add_commit) begin
        if (add_full) begin
          ovf_q <= 1'b1;
        end else begin
          nz_q[a_q][b_q] <= 1'b1;
          nz_q[b_q][a_q] <= 1'b1;
          par_q[a_q]     <= ~par_q[a_q];
          par_q[b_q]     <= ~par_q[b_q];
          total_q        <= total_q + TW'(1);
        end
      end
      if (cmd_i.take) begin
        if (cnt_q == CNT_W'(1)) begin
          nz_q[cur_q][v_q] <= 1'b0;
          nz_q[v_q][cur_q] <= 1'b0;
        end
        par_q[cur_q] <= ~par_q[cur_q];
        par_q[v_q]   <= ~par_q[v_q];
        pend_v_q     <= 1'b1;
      end
      if ((cmd_i.check && err) || cmd_i.finish) begin
        for (int i = 0; i < NV; i++) nz_q[i] <= '0;
        par_q    <= '0;
        total_q  <= '0;
        ovf_q    <= 1'b0;
        pend_v_q <= 1'b0;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_add) begin
      a_q    <= a_idx;
      b_q    <= b_idx;
      addr_q <= pair_addr(a_idx, b_idx);
    end
    if (cmd_i.check) begin
      cur_q <= highest(par_q);
      rem_q <= nz_q[highest(par_q)];
    end
    if (cmd_i.pick) begin
      v_q    <= pick_v;
      addr_q <= pair_addr(cur_q, pick_v);
    end
    if (cmd_i.test_cnt) begin
      cnt_q <= ram_rdata;
      vis_q <= NV'(1) << cur_q;
    end
    if (cmd_i.reach_step) begin
      vis_q <= vis_d;
      if (vis_d == vis_q && !vis_d[v_q]) rem_q[v_q] <= 1'b0;
    end
    if (cmd_i.take) begin
      pend_from_q <= cur_q;
      pend_to_q   <= v_q;
      cur_q       <= v_q;
      rem_q       <= next_row;
    end
  end

  // result register, one beat per strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (cmd_i.check && err) || cmd_i.finish || (cmd_i.take && pend_v_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check && err) begin
      res_status_q <= err_code;
      res_from_q   <= '0;
      res_to_q     <= '0;
      res_last_q   <= 1'b1;
    end else if (cmd_i.finish) begin
      res_status_q <= pend_v_q ? ST_EDGE : ST_EMPTY;
      res_from_q   <= pend_v_q ? pend_from_q : '0;
      res_to_q     <= pend_v_q ? pend_to_q : '0;
      res_last_q   <= 1'b1;
    end else if (cmd_i.take) begin
      res_status_q <= ST_EDGE;
      res_from_q   <= pend_from_q;
      res_to_q     <= pend_to_q;
      res_last_q   <= 1'b0;
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign from_vertex_o  = to_port(res_from_q);
  assign to_vertex_o    = to_port(res_to_q);
  assign last_o         = res_last_q;

endmodule

>>> hw/rtl/etf_ctrl.sv
// etf_ctrl: sequencing state machine of the euler trail unit
// depends on etf_pkg
module etf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          action_i,
  input  etf_pkg::sts_t sts_i,
  output etf_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import etf_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ADD   = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_PICK  = 8'b0000_1000,
    S_CNT   = 8'b0001_0000,
    S_REACH = 8'b0010_0000,
    S_TAKE  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (action_i == ACT_RUN) begin
            state_d = S_CHECK;
          end else if (sts_i.add_ok) begin
            cmd_o.latch_add = 1'b1;
            state_d         = S_ADD;
          end
        end
      end
      S_ADD: begin
        cmd_o.add_commit = 1'b1;
        state_d          = S_IDLE;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.check_err ? S_IDLE : S_PICK;
      end
      S_PICK: begin
        if (sts_i.pick_none) begin
          state_d = S_DONE;
        end else begin
          cmd_o.pick = 1'b1;
          state_d    = S_CNT;
        end
      end
      S_CNT: begin
        cmd_o.test_cnt = 1'b1;
        state_d        = sts_i.cnt_take ? S_TAKE : S_REACH;
      end
      S_REACH: begin
        cmd_o.reach_step = 1'b1;
        if (sts_i.reach_hit) begin
          state_d = S_TAKE;
        end else if (sts_i.reach_stable) begin
          state_d = S_PICK;
        end
      end
      S_TAKE: begin
        cmd_o.take = 1'b1;
        state_d    = S_PICK;
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> hw/rtl/euler_trail_fleury_unit.sv
// euler_trail_fleury_unit: top level of the fleury euler trail unit
// depends on etf_pkg, etf_ctrl, etf_datapath (and through it etf_ram)
//
// usage: drive start_i with action_i = 0 to load an undirected edge
// vertex_a_i - vertex_b_i (self-loops and out-of-range endpoints are
// ignored), and action_i = 1 to run the trail search. a beat is taken at
// a rising edge with start_i high and busy_o low. a valid edge load keeps
// busy_o high for one cycle (count read, then write back), so the next
// load waits for the write back; an ignored load leaves busy_o low. a
// run answers either one error beat (status overflow, empty or not
// eulerian, with last_o set) or one beat per trail edge, the final one
// with last_o set. each result beat sits on the result ports for exactly
// one cycle under result_valid_o; the receiver cannot stall, so it must
// take every beat. a run first spends a busy state on its checks, and an
// error beat is registered from that state. after that each neighbor
// tried passes the pick and count read states, a taken edge also the
// take state, and a neighbor whose last parallel edge is under test also
// the reachability closure state; the walk ends with an empty pick and
// finish. the ram port for pair counts and the one-step closure pace
// this walk. every run clears the edge store at its end.
module euler_trail_fleury_unit #(
  parameter int NUM_VERTICES = etf_pkg::NUM_VERTICES_DEF,
  parameter int MAX_EDGES    = etf_pkg::MAX_EDGES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      action_i,
  input  logic [etf_pkg::VTX_W-1:0] vertex_a_i,
  input  logic [etf_pkg::VTX_W-1:0] vertex_b_i,
  output logic                      result_valid_o,
  output logic [1:0]                status_o,
  output logic [etf_pkg::VTX_W-1:0] from_vertex_o,
  output logic [etf_pkg::VTX_W-1:0] to_vertex_o,
  output logic                      last_o
);
  import etf_pkg::*;

  // command and status between the sequencer and the datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: load, check, pick neighbor, test count, closure, take, finish
  etf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .action_i(action_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // datapath: pair counts, adjacency bits, degree parity and result beat
  etf_datapath #(
    .NUM_VERTICES(NUM_VERTICES),
    .MAX_EDGES   (MAX_EDGES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .vertex_a_i    (vertex_a_i),
    .vertex_b_i    (vertex_b_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .from_vertex_o (from_vertex_o),
    .to_vertex_o   (to_vertex_o),
    .last_o        (last_o)
  );

endmodule
